// ----- sv/rbswc_pkg.sv -----
package rbswc_pkg;

  // Field and datapath widths
  localparam int unsigned FIX_W      = 32;
  localparam int unsigned SQ_W       = 64;
  localparam int unsigned ENERGY_W   = 48;
  localparam int unsigned CD_W       = 34;
  localparam int unsigned CD_OUT_W   = 33;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned NUM_LANES  = 3;

  // Cycles spent in the datapath before the decision is taken
  localparam int unsigned RUN_CYCLES = 5;
  localparam int unsigned RUN_CNT_W  = 3;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

  // Register reset values
  localparam logic [FIX_W-1:0]    FORCE_THR_RST  = 32'd65536;
  localparam logic [FIX_W-1:0]    ACCEL_THR_RST  = 32'd65536;
  localparam logic [FIX_W-1:0]    TORQUE_THR_RST = 32'd65536;
  localparam logic [FIX_W-1:0]    LIN_THR_RST    = 32'd6554;
  localparam logic [FIX_W-1:0]    ANG_THR_RST    = 32'd6554;
  localparam logic [ENERGY_W-1:0] ENERGY_THR_RST = 48'd6554;
  localparam logic [FIX_W-1:0]    DELAY_RST      = 32'd65536;
  localparam logic [FIX_W-1:0]    MASS_RST       = 32'd65536;

  typedef logic signed [FIX_W-1:0] fix_t;
  typedef logic [FIX_W-1:0]        ufix_t;
  typedef logic [SQ_W-1:0]         sq_t;
  typedef logic [ENERGY_W-1:0]     energy_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORCE_THR  = 3'd0,
    CFG_ACCEL_THR  = 3'd1,
    CFG_TORQUE_THR = 3'd2,
    CFG_LIN_THR    = 3'd3,
    CFG_ANG_THR    = 3'd4,
    CFG_ENERGY_THR = 3'd5,
    CFG_DELAY      = 3'd6,
    CFG_MASS       = 3'd7
  } cfg_idx_t;

  typedef enum logic {
    REQ_WAKE  = 1'b0,
    REQ_SLEEP = 1'b1
  } req_kind_t;

  // Findings of the merge stage handed to the controller
  typedef struct packed {
    logic wake_hit;
    logic lin_below;
    logic ang_below;
    logic energy_below;
  } rbswc_status_t;

  // Magnitude of a Q16.16 value, exact for the most negative code
  function automatic ufix_t mag32(input fix_t v);
    return v[FIX_W-1] ? (~v + 32'd1) : v;
  endfunction

  // Join two 32-bit-split partial products, shift by 33, saturate to 48 bits
  function automatic energy_t shr33_sat(input sq_t p_lo, input sq_t p_hi);
    logic [95:0] full;
    full = {p_hi, 32'd0} + {32'd0, p_lo};
    if (full[95:81] != '0) begin
      return ENERGY_MAX;
    end
    return full[80:33];
  endfunction

endpackage

// ----- sv/rbswc_if.sv -----
interface rbswc_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic        recent_collision;
  logic [31:0] delta_time;
  logic signed [31:0] vec_a_x;
  logic signed [31:0] vec_a_y;
  logic signed [31:0] vec_a_z;
  logic signed [31:0] vec_b_x;
  logic signed [31:0] vec_b_y;
  logic signed [31:0] vec_b_z;
  logic signed [31:0] vec_c_x;
  logic signed [31:0] vec_c_y;
  logic signed [31:0] vec_c_z;

  modport source (
    output valid, req_type, recent_collision, delta_time,
    output vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z,
    output vec_c_x, vec_c_y, vec_c_z,
    input  ready
  );
  modport sink (
    input  valid, req_type, recent_collision, delta_time,
    input  vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z,
    input  vec_c_x, vec_c_y, vec_c_z,
    output ready
  );
endinterface

interface rbswc_out_if;
  logic        valid;
  logic        ready;
  logic        is_asleep;
  logic        woke_now;
  logic        slept_now;
  logic signed [32:0] countdown_left;

  modport source (
    output valid, is_asleep, woke_now, slept_now, countdown_left,
    input  ready
  );
  modport sink (
    input  valid, is_asleep, woke_now, slept_now, countdown_left,
    output ready
  );
endinterface

// ----- sv/rbswc_lane.sv -----
module rbswc_lane (
  input  logic              clk,
  input  rbswc_pkg::fix_t   vec_a,
  input  rbswc_pkg::fix_t   vec_b,
  input  rbswc_pkg::fix_t   vec_c,
  output rbswc_pkg::sq_t    sq_a,
  output rbswc_pkg::sq_t    sq_b,
  output rbswc_pkg::sq_t    sq_c,
  output rbswc_pkg::energy_t ang_e
);
  import rbswc_pkg::*;

  ufix_t       mag_a;
  ufix_t       mag_b;
  ufix_t       mag_c;
  logic [30:0] inertia;
  sq_t         p_lo;
  sq_t         p_hi;

  assign mag_a = mag32(vec_a);
  assign mag_b = mag32(vec_b);
  assign mag_c = mag32(vec_c);

  // Negative inertia contributes no energy
  assign inertia = vec_c[FIX_W-1] ? '0 : vec_c[30:0];

  // Square each component of this axis
  always_ff @(posedge clk) begin
    sq_a <= {32'd0, mag_a} * {32'd0, mag_a};
    sq_b <= {32'd0, mag_b} * {32'd0, mag_b};
    sq_c <= {32'd0, mag_c} * {32'd0, mag_c};
  end

  // Split inertia times squared angular speed into two 32-bit halves
  always_ff @(posedge clk) begin
    p_lo <= {33'd0, inertia} * {32'd0, sq_b[31:0]};
    p_hi <= {33'd0, inertia} * {32'd0, sq_b[63:32]};
  end

  // Combine halves into the saturated angular energy term
  always_ff @(posedge clk) begin
    ang_e <= shr33_sat(p_lo, p_hi);
  end

endmodule

// ----- sv/rbswc_merge.sv -----
module rbswc_merge (
  input  logic                                  clk,
  input  rbswc_pkg::sq_t [rbswc_pkg::NUM_LANES-1:0]     sq_a,
  input  rbswc_pkg::sq_t [rbswc_pkg::NUM_LANES-1:0]     sq_b,
  input  rbswc_pkg::sq_t [rbswc_pkg::NUM_LANES-1:0]     sq_c,
  input  rbswc_pkg::energy_t [rbswc_pkg::NUM_LANES-1:0] ang_e,
  input  rbswc_pkg::ufix_t                      force_threshold,
  input  rbswc_pkg::ufix_t                      accel_threshold,
  input  rbswc_pkg::ufix_t                      torque_threshold,
  input  rbswc_pkg::ufix_t                      lin_speed_threshold,
  input  rbswc_pkg::ufix_t                      ang_speed_threshold,
  input  rbswc_pkg::energy_t                    energy_threshold,
  input  rbswc_pkg::ufix_t                      linear_mass,
  output rbswc_pkg::rbswc_status_t              status
);
  import rbswc_pkg::*;

  sq_t         sum_a;
  sq_t         sum_b;
  sq_t         sum_c;
  sq_t         force_sq;
  sq_t         accel_sq;
  sq_t         torque_sq;
  sq_t         lin_sq;
  sq_t         ang_sq;
  sq_t         lin_lo;
  sq_t         lin_hi;
  energy_t     lin_e;
  logic        wake_hit;
  logic        lin_below;
  logic        ang_below;
  logic        energy_below;
  logic [49:0] e_total;
  energy_t     e_sat;

  // Add the lane squares and square the thresholds
  always_ff @(posedge clk) begin
    sum_a     <= sq_a[0] + sq_a[1] + sq_a[2];
    sum_b     <= sq_b[0] + sq_b[1] + sq_b[2];
    sum_c     <= sq_c[0] + sq_c[1] + sq_c[2];
    force_sq  <= {32'd0, force_threshold} * {32'd0, force_threshold};
    accel_sq  <= {32'd0, accel_threshold} * {32'd0, accel_threshold};
    torque_sq <= {32'd0, torque_threshold} * {32'd0, torque_threshold};
    lin_sq    <= {32'd0, lin_speed_threshold} * {32'd0, lin_speed_threshold};
    ang_sq    <= {32'd0, ang_speed_threshold} * {32'd0, ang_speed_threshold};
  end

  // Compare magnitudes and start the linear energy product
  always_ff @(posedge clk) begin
    wake_hit  <= (sum_a > force_sq) || (sum_b > accel_sq) || (sum_c > torque_sq);
    lin_below <= sum_a < lin_sq;
    ang_below <= sum_b < ang_sq;
    lin_lo    <= {32'd0, linear_mass} * {32'd0, sum_a[31:0]};
    lin_hi    <= {32'd0, linear_mass} * {32'd0, sum_a[63:32]};
  end

  always_ff @(posedge clk) begin
    lin_e <= shr33_sat(lin_lo, lin_hi);
  end

  // Total energy saturates once at the end since every term is non-negative
  assign e_total = {2'd0, lin_e} + {2'd0, ang_e[0]} + {2'd0, ang_e[1]} + {2'd0, ang_e[2]};
  assign e_sat   = (e_total > {2'd0, ENERGY_MAX}) ? ENERGY_MAX : e_total[ENERGY_W-1:0];

  always_ff @(posedge clk) begin
    energy_below <= e_sat < energy_threshold;
  end

  assign status = '{wake_hit:     wake_hit,
                    lin_below:    lin_below,
                    ang_below:    ang_below,
                    energy_below: energy_below};

endmodule

// ----- sv/rigid_body_sleep_wake_controller.sv -----
// Sleep/wake controller for one rigid body. Each request item is a wake check
// (req_type 0: collision flag, force, acceleration, torque) or a sleep check
// (req_type 1: velocity, angular velocity, inertia, delta_time) and yields one
// response item with the activity state, wake/sleep event bits and the signed
// Q16.16 countdown. One item is in flight at a time: the request is taken,
// three axis lanes square the components and form the angular energy terms,
// a merge stage sums and compares them, and the state is then updated; a new
// item is taken only after the previous one has been decided and its response
// emitted; the run length is set by the split 32x64 energy products. Write
// the configuration registers only while no item is in progress; a new sleep
// delay takes effect at the next countdown reload.
module rigid_body_sleep_wake_controller (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_we,
  input  logic [rbswc_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [rbswc_pkg::CFG_DATA_W-1:0]          cfg_data,
  rbswc_in_if.sink                                  req,
  rbswc_out_if.source                               rsp
);
  import rbswc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_RUN    = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic [RUN_CNT_W-1:0]   run_cnt;

  // Configuration registers
  ufix_t   force_threshold;
  ufix_t   accel_threshold;
  ufix_t   torque_threshold;
  ufix_t   lin_speed_threshold;
  ufix_t   ang_speed_threshold;
  energy_t energy_threshold;
  ufix_t   sleep_delay;
  ufix_t   linear_mass;

  // Body state
  logic                   asleep;
  logic                   asleep_next;
  logic signed [CD_W-1:0] countdown;
  logic signed [CD_W-1:0] countdown_next;
  logic signed [CD_W-1:0] countdown_dec;
  logic                   woke;
  logic                   slept;

  // Held request item
  req_kind_t               item_kind;
  logic                    item_collision;
  ufix_t                   item_dt;
  fix_t [NUM_LANES-1:0]    item_a;
  fix_t [NUM_LANES-1:0]    item_b;
  fix_t [NUM_LANES-1:0]    item_c;

  sq_t [NUM_LANES-1:0]     lane_sq_a;
  sq_t [NUM_LANES-1:0]     lane_sq_b;
  sq_t [NUM_LANES-1:0]     lane_sq_c;
  energy_t [NUM_LANES-1:0] lane_ang_e;
  rbswc_status_t           status;

  logic in_fire;
  logic emit;

  assign req.ready = (state == S_IDLE);
  assign in_fire   = req.valid && req.ready;
  assign emit      = (state == S_DECIDE) && (!rsp.valid || rsp.ready);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      force_threshold     <= FORCE_THR_RST;
      accel_threshold     <= ACCEL_THR_RST;
      torque_threshold    <= TORQUE_THR_RST;
      lin_speed_threshold <= LIN_THR_RST;
      ang_speed_threshold <= ANG_THR_RST;
      energy_threshold    <= ENERGY_THR_RST;
      sleep_delay         <= DELAY_RST;
      linear_mass         <= MASS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FORCE_THR:  force_threshold     <= cfg_data[FIX_W-1:0];
        CFG_ACCEL_THR:  accel_threshold     <= cfg_data[FIX_W-1:0];
        CFG_TORQUE_THR: torque_threshold    <= cfg_data[FIX_W-1:0];
        CFG_LIN_THR:    lin_speed_threshold <= cfg_data[FIX_W-1:0];
        CFG_ANG_THR:    ang_speed_threshold <= cfg_data[FIX_W-1:0];
        CFG_ENERGY_THR: energy_threshold    <= cfg_data[ENERGY_W-1:0];
        CFG_DELAY:      sleep_delay         <= cfg_data[FIX_W-1:0];
        CFG_MASS:       linear_mass         <= cfg_data[FIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the request item
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_kind      <= req_kind_t'(req.req_type);
      item_collision <= req.recent_collision;
      item_dt        <= req.delta_time;
      item_a         <= {req.vec_a_z, req.vec_a_y, req.vec_a_x};
      item_b         <= {req.vec_b_z, req.vec_b_y, req.vec_b_x};
      item_c         <= {req.vec_c_z, req.vec_c_y, req.vec_c_x};
    end
  end

  // One lane per axis
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    rbswc_lane u_lane (
      .clk   (clk),
      .vec_a (item_a[g]),
      .vec_b (item_b[g]),
      .vec_c (item_c[g]),
      .sq_a  (lane_sq_a[g]),
      .sq_b  (lane_sq_b[g]),
      .sq_c  (lane_sq_c[g]),
      .ang_e (lane_ang_e[g])
    );
  end

  rbswc_merge u_merge (
    .clk                 (clk),
    .sq_a                (lane_sq_a),
    .sq_b                (lane_sq_b),
    .sq_c                (lane_sq_c),
    .ang_e               (lane_ang_e),
    .force_threshold     (force_threshold),
    .accel_threshold     (accel_threshold),
    .torque_threshold    (torque_threshold),
    .lin_speed_threshold (lin_speed_threshold),
    .ang_speed_threshold (ang_speed_threshold),
    .energy_threshold    (energy_threshold),
    .linear_mass         (linear_mass),
    .status              (status)
  );

  // Sequence: take item, wait for the datapath, decide
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_fire) state_next = S_RUN;
      S_RUN:    if (run_cnt == RUN_CNT_W'(RUN_CYCLES - 1)) state_next = S_DECIDE;
      S_DECIDE: if (emit) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      run_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_RUN) begin
        run_cnt <= run_cnt + RUN_CNT_W'(1);
      end else begin
        run_cnt <= '0;
      end
    end
  end

  // Decide the new activity state and countdown
  assign countdown_dec = countdown - $signed({2'd0, item_dt});

  always_comb begin
    asleep_next    = asleep;
    countdown_next = countdown;
    woke           = 1'b0;
    slept          = 1'b0;
    case (item_kind)
      REQ_WAKE: begin
        if (asleep && (item_collision || status.wake_hit)) begin
          asleep_next    = 1'b0;
          countdown_next = $signed({2'd0, sleep_delay});
          woke           = 1'b1;
        end
      end
      REQ_SLEEP: begin
        if (!asleep) begin
          if (status.lin_below && status.ang_below) begin
            if (status.energy_below) begin
              countdown_next = countdown_dec;
              if (countdown_dec <= 0) begin
                asleep_next = 1'b1;
                slept       = 1'b1;
              end
            end
          end else begin
            countdown_next = $signed({2'd0, sleep_delay});
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      asleep    <= 1'b0;
      countdown <= $signed({2'd0, DELAY_RST});
    end else if (emit) begin
      asleep    <= asleep_next;
      countdown <= countdown_next;
    end
  end

  // Hold the response item until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (emit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.is_asleep      <= asleep_next;
      rsp.woke_now       <= woke;
      rsp.slept_now      <= slept;
      rsp.countdown_left <= countdown_next[CD_OUT_W-1:0];
    end
  end

  a_take_starts_run: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == S_RUN))
    else $error("accepted item did not start the datapath run");

  a_events_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.woke_now && rsp.slept_now))
    else $error("item both woke and slept the body");

  a_woke_is_awake: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.woke_now) |-> !rsp.is_asleep)
    else $error("woken body reported asleep");

  a_slept_countdown: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.slept_now) |->
      (rsp.is_asleep && (rsp.countdown_left[CD_OUT_W-1] || rsp.countdown_left == '0)))
    else $error("body slept with countdown above zero");

endmodule
